// ----- src/psdf_pkg.sv -----
// ----------------------------------------------------------------------------
// psdf_pkg: shared types and constants
// Record type, sort order and the small constants used across the sorter.
// ----------------------------------------------------------------------------
package psdf_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_AW        = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] BOUND_RESET = 32'd10000;

  // configuration register indexes
  localparam logic CFG_CLASS = 1'b0;
  localparam logic CFG_BOUND = 1'b1;

  // priority class codes
  localparam logic [1:0] CLASS_ALL   = 2'd0;
  localparam logic [1:0] CLASS_ABOVE = 2'd1;
  localparam logic [1:0] CLASS_BELOW = 2'd2;

  typedef struct packed {
    logic [31:0] prio;
    logic [31:0] pkg;
    logic [15:0] idx;
  } rec_t;

  // word passed from the front queue to the back end
  typedef struct packed {
    rec_t rec;
    logic last;
  } qword_t;

  typedef struct packed {
    logic [1:0]  pclass;
    logic [31:0] bound;
  } cfg_t;

  // back-end control towards the insertion chain
  typedef struct packed {
    logic ins;
    logic pop;
    logic fin;
  } chain_ctl_t;

  // head of the chain as seen by the emit control
  typedef struct packed {
    logic valid;
    rec_t rec;
    logic ovf;
  } chain_head_t;

  // true when record a sorts strictly after record b
  function automatic logic rec_after(rec_t a, rec_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = (a.prio < b.prio);
    end else if (a.pkg != b.pkg) begin
      res = (a.pkg > b.pkg);
    end else begin
      res = (a.idx > b.idx);
    end
    return res;
  endfunction

  function automatic logic class_keeps(cfg_t cfg, logic [31:0] prio);
    logic res;
    case (cfg.pclass)
      CLASS_ABOVE: res = (prio >= cfg.bound);
      CLASS_BELOW: res = (prio < cfg.bound);
      default:     res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

// ----- src/psdf_if.sv -----
// ----------------------------------------------------------------------------
// psdf_if: channel interfaces
// Valid/ready channels for input records and sorted results.
// ----------------------------------------------------------------------------
interface psdf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] package_number;
  logic [15:0] trigger_index;
  logic [31:0] priority_req;
  logic        last_in;

  modport source (output valid, package_number, trigger_index, priority_req, last_in,
                  input ready);
  modport sink   (input valid, package_number, trigger_index, priority_req, last_in,
                  output ready);
endinterface

interface psdf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_package_number;
  logic [15:0] out_trigger_index;
  logic [31:0] out_priority;
  logic        valid_res;
  logic        overflowed;
  logic        last_out;

  modport source (output valid, out_package_number, out_trigger_index, out_priority,
                  valid_res, overflowed, last_out,
                  input ready);
  modport sink   (input valid, out_package_number, out_trigger_index, out_priority,
                  valid_res, overflowed, last_out,
                  output ready);
endinterface

// ----- src/priority_sort_dedup_filter_core.sv -----
// ----------------------------------------------------------------------------
// priority_sort_dedup_filter_core: batch sorter with duplicate removal
// Top level: configuration registers, input queue, insertion chain, emitter.
// ----------------------------------------------------------------------------
// Records of a batch are taken one per cycle while the queue holds one and no
// drain is running, and dropped straight into their sorted place in a register
// chain of MAX_ENTRIES cells (priority descending, package ascending, index
// ascending); records beyond capacity are dropped and flagged. Once the record
// marked last is in, the chain shifts out one entry per cycle while the output
// is free, with exact duplicates and records outside the priority class skipped
// and the final result marked. An empty batch yields one result with valid_res
// low. A four-word input queue keeps taking records of the next batch while a
// batch drains; the chain takes no new record until that drain is over.
// Configuration is to be written only while idle; the block does not check it.
module priority_sort_dedup_filter_core #(
  parameter int unsigned MAX_ENTRIES = psdf_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  psdf_in_if.sink     in_ch,
  psdf_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  psdf_pkg::cfg_t        cfg_r;
  psdf_pkg::qword_t      q_word;
  logic                  q_valid, q_pop;
  psdf_pkg::chain_ctl_t  ctl;
  psdf_pkg::chain_head_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pclass <= psdf_pkg::CLASS_ALL;
      cfg_r.bound  <= psdf_pkg::BOUND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        psdf_pkg::CFG_CLASS: cfg_r.pclass <= cfg_wdata[1:0];
        psdf_pkg::CFG_BOUND: cfg_r.bound  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  psdf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop)
  );

  psdf_chain #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .new_rec (q_word.rec),
    .head    (head)
  );

  psdf_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop),
    .ctl     (ctl),
    .head    (head),
    .out_ch  (out_ch)
  );

endmodule

// ----- src/psdf_front.sv -----
// ----------------------------------------------------------------------------
// psdf_front: input queue
// Accepts words from the input channel, packs them into records and holds
// them in a short queue so the back end can stall independently.
// ----------------------------------------------------------------------------
module psdf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  psdf_in_if.sink              in_ch,
  output logic                 q_valid,
  output psdf_pkg::qword_t     q_word,
  input  logic                 q_pop
);

  localparam int unsigned AW = psdf_pkg::QUEUE_AW;
  localparam logic [AW:0] FULL_C = (AW+1)'(psdf_pkg::QUEUE_DEPTH);

  psdf_pkg::qword_t mem_r [psdf_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             push, pop;
  psdf_pkg::qword_t in_word;

  always_comb begin
    in_word.rec.prio = in_ch.priority_req;
    in_word.rec.pkg  = in_ch.package_number;
    in_word.rec.idx  = in_ch.trigger_index;
    in_word.last     = in_ch.last_in;
  end

  assign in_ch.ready = (cnt_r != FULL_C);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_word      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_word;
    end
  end

endmodule

// ----- src/psdf_chain.sv -----
// ----------------------------------------------------------------------------
// psdf_chain: insertion chain
// Row of record cells kept in sort order; a new record drops straight into
// place, and the chain shifts towards the head when draining.
// ----------------------------------------------------------------------------
module psdf_chain #(
  parameter int unsigned MAX_ENTRIES = psdf_pkg::MAX_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  psdf_pkg::chain_ctl_t    ctl,
  input  psdf_pkg::rec_t          new_rec,
  output psdf_pkg::chain_head_t   head
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_C = CW'(MAX_ENTRIES);

  psdf_pkg::rec_t cell_r [MAX_ENTRIES];
  psdf_pkg::rec_t cell_nxt [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] vld_r, vld_nxt, after;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   full;

  assign full = (cnt_r == FULL_C);

  // invalid cells count as free slots at the tail
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      after[i] = vld_r[i] ? psdf_pkg::rec_after(cell_r[i], new_rec) : 1'b1;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cell_nxt[i] = cell_r[i];
      vld_nxt[i]  = vld_r[i];
    end
    if (ctl.fin) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (ctl.pop) begin
      for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
        cell_nxt[i] = cell_r[i+1];
        vld_nxt[i]  = vld_r[i+1];
      end
      vld_nxt[MAX_ENTRIES-1] = 1'b0;
    end else if (ctl.ins) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (after[i]) begin
            if (i == 0) begin
              cell_nxt[i] = new_rec;
              vld_nxt[i]  = 1'b1;
            end else if (!after[i-1]) begin
              cell_nxt[i] = new_rec;
              vld_nxt[i]  = 1'b1;
            end else begin
              cell_nxt[i] = cell_r[i-1];
              vld_nxt[i]  = vld_r[i-1];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  assign head.valid = vld_r[0];
  assign head.rec   = cell_r[0];
  assign head.ovf   = ovf_r;

endmodule

// ----- src/psdf_emit.sv -----
// ----------------------------------------------------------------------------
// psdf_emit: back-end control and output stage
// Loads queued records into the chain, then drains it in order, dropping
// duplicates and filtered records, and marks the final result of a batch.
// ----------------------------------------------------------------------------
module psdf_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  psdf_pkg::cfg_t         cfg,
  input  logic                   q_valid,
  input  psdf_pkg::qword_t       q_word,
  output logic                   q_pop,
  output psdf_pkg::chain_ctl_t   ctl,
  input  psdf_pkg::chain_head_t  head,
  psdf_out_if.source             out_ch
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic           st_r, st_nxt;
  psdf_pkg::rec_t prev_r, pend_r;
  logic           have_prev_r, have_prev_nxt;
  logic           pend_v_r, pend_v_nxt;

  logic           ov_r, ov_nxt;
  psdf_pkg::rec_t orec_r;
  logic           ores_r, oovf_r, olast_r;

  logic           out_free, dup, keep, load_out, take_head;
  psdf_pkg::rec_t load_rec;
  logic           load_res, load_last;

  assign out_free  = !ov_r || out_ch.ready;
  assign dup       = have_prev_r && (prev_r == head.rec);
  assign keep      = !dup && psdf_pkg::class_keeps(cfg, head.rec.prio);
  assign take_head = (st_r == ST_DRAIN) && out_free && head.valid;

  assign q_pop   = (st_r == ST_LOAD) && q_valid;
  assign ctl.ins = q_pop;
  assign ctl.pop = take_head;
  assign ctl.fin = (st_r == ST_DRAIN) && out_free && !head.valid;

  always_comb begin
    st_nxt        = st_r;
    have_prev_nxt = have_prev_r;
    pend_v_nxt    = pend_v_r;
    load_out      = 1'b0;
    load_rec      = pend_r;
    load_res      = 1'b1;
    load_last     = 1'b0;
    case (st_r)
      ST_LOAD: begin
        if (q_valid && q_word.last) begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (take_head) begin
          have_prev_nxt = 1'b1;
          if (keep) begin
            pend_v_nxt = 1'b1;
            load_out   = pend_v_r;
          end
        end else if (ctl.fin) begin
          // close the batch: held record goes out last, or the empty marker
          load_out      = 1'b1;
          load_last     = 1'b1;
          load_res      = pend_v_r;
          if (!pend_v_r) begin
            load_rec = '0;
          end
          pend_v_nxt    = 1'b0;
          have_prev_nxt = 1'b0;
          st_nxt        = ST_LOAD;
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  assign ov_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_LOAD;
      have_prev_r <= 1'b0;
      pend_v_r    <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      have_prev_r <= have_prev_nxt;
      pend_v_r    <= pend_v_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_head) begin
      prev_r <= head.rec;
      if (keep) begin
        pend_r <= head.rec;
      end
    end
    if (load_out) begin
      orec_r  <= load_rec;
      ores_r  <= load_res;
      oovf_r  <= head.ovf;
      olast_r <= load_last;
    end
  end

  assign out_ch.valid              = ov_r;
  assign out_ch.out_package_number = orec_r.pkg;
  assign out_ch.out_trigger_index  = orec_r.idx;
  assign out_ch.out_priority       = orec_r.prio;
  assign out_ch.valid_res          = ores_r;
  assign out_ch.overflowed         = oovf_r;
  assign out_ch.last_out           = olast_r;

endmodule
